/* sv/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: beat payloads,
// opcodes, register indexes, character codes and the sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = CFG_INDEX_W'(1);
  localparam logic [CFG_DATA_W-1:0]  FOREGROUND_RST = CFG_DATA_W'(7);
  localparam logic [CFG_DATA_W-1:0]  BACKGROUND_RST = CFG_DATA_W'(0);

  // Character codes
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Cell written by the clearing pass after reset
  localparam logic [15:0] BLANK_RST = 16'h0720;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } tcw_op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tcw_cmd_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [15:0] read_cell;
    logic        did_scroll;
  } tcw_result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUT,
    ST_WRITE,
    ST_SCROLL,
    ST_FLUSH,
    ST_BLANK,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } tcw_state_t;

endpackage

/* sv/tcw_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cmd_if
// Command channel: one beat carries an opcode, a character and a cell index.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  char_code;
  logic [10:0] cell_index;

  modport source (output valid, output opcode, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input opcode, input char_code, input cell_index,
                  output ready);
endinterface

/* sv/tcw_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: cursor position, read cell and scroll flag per command.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_column;
  logic [15:0] read_cell;
  logic        did_scroll;

  modport source (output valid, output cursor_row, output cursor_column,
                  output read_cell, output did_scroll, input ready);
  modport sink   (input valid, input cursor_row, input cursor_column,
                  input read_cell, input did_scroll, output ready);
endinterface

/* sv/tcw_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcw_cfg_if;
  import tcw_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/tcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/tcw_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_seq
// Command sequencer: cursor arithmetic, cell writes, the row copy of a
// scroll, blanking sweeps and cell reads, with one adder for put addresses and ptr steps.
// ----------------------------------------------------------------------------
module tcw_seq import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst,
  // command beat
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  tcw_cmd_t          cmd,
  // current attribute byte
  input  logic [7:0]        attr,
  // result hand-off to the output register
  output logic              res_valid,
  input  logic              res_ready,
  output tcw_result_t       res,
  // cell store
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [15:0]       ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [15:0]       ram_rdata
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

  tcw_state_t state, state_next;

  logic              init;
  tcw_op_t           op;
  logic [7:0]        ch;
  logic [10:0]       idx;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic              scrolled;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] wptr;
  logic              pend;
  logic              in_range;
  logic [15:0]       cell_data;

  logic              printable;
  logic [COL_W:0]    c_ext;
  logic [ROW_W:0]    r_ext;
  logic              scroll_need;
  logic [ADDR_W-1:0] au_a, au_b, au_sum;

  assign printable = !(ch inside {CH_NEWLINE, CH_RETURN, CH_TAB});

  // Shared address adder: cell address on a put, pointer step in sweeps
  always_comb begin
    if (state == ST_PUT) begin
      au_a = ADDR_W'(row * COLUMNS);
      au_b = ADDR_W'(col);
    end else begin
      au_a = ptr;
      au_b = ADDR_W'(1);
    end
  end
  assign au_sum = au_a + au_b;

  // Cursor advance for a put
  always_comb begin
    c_ext       = {1'b0, col};
    r_ext       = {1'b0, row};
    scroll_need = 1'b0;
    if (ch == CH_NEWLINE) begin
      c_ext = '0;
      r_ext = r_ext + 1'b1;
    end else if (ch == CH_RETURN) begin
      c_ext = '0;
    end else if (ch == CH_TAB) begin
      c_ext = (c_ext + (COL_W + 1)'(8)) & ~(COL_W + 1)'(7);
    end else begin
      c_ext = c_ext + 1'b1;
    end
    if (c_ext >= (COL_W + 1)'(COLUMNS)) begin
      c_ext = '0;
      r_ext = r_ext + 1'b1;
    end
    if (r_ext >= (ROW_W + 1)'(ROWS)) begin
      r_ext       = (ROW_W + 1)'(ROWS - 1);
      scroll_need = 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BLANK;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store access
  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ptr;
    ram_wdata  = {attr, CH_SPACE};
    ram_raddr  = ptr;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (tcw_op_t'(cmd.opcode))
            OP_PUT:   state_next = ST_PUT;
            OP_CLEAR: state_next = ST_BLANK;
            OP_READ:  state_next = ST_READ;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_PUT: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we     = printable;
        ram_waddr  = addr;
        ram_wdata  = {attr, ch};
        state_next = scrolled ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        ram_we    = pend;
        ram_waddr = wptr;
        ram_wdata = ram_rdata;
        if (ptr == LAST_CELL) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        ram_we     = pend;
        ram_waddr  = wptr;
        ram_wdata  = ram_rdata;
        state_next = ST_BLANK;
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = init ? BLANK_RST : {attr, CH_SPACE};
        if (ptr == LAST_CELL) begin
          state_next = init ? ST_IDLE : ST_DONE;
        end
      end
      ST_READ: begin
        ram_raddr  = ADDR_W'(idx);
        state_next = ST_RDATA;
      end
      ST_RDATA: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init <= 1'b1;
      row  <= '0;
      col  <= '0;
      ptr  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= (state == ST_SCROLL);
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            ptr <= '0;
            if (tcw_op_t'(cmd.opcode) == OP_CLEAR) begin
              row <= '0;
              col <= '0;
            end
          end
        end
        ST_PUT: begin
          row <= r_ext[ROW_W-1:0];
          col <= c_ext[COL_W-1:0];
        end
        ST_WRITE: begin
          ptr <= ROW_STRIDE;
        end
        ST_SCROLL: begin
          ptr <= au_sum;
        end
        ST_FLUSH: begin
          ptr <= BOTTOM_ROW;
        end
        ST_BLANK: begin
          ptr <= au_sum;
          if (ptr == LAST_CELL) begin
            init <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          op        <= tcw_op_t'(cmd.opcode);
          ch        <= cmd.char_code;
          idx       <= cmd.cell_index;
          scrolled  <= 1'b0;
          cell_data <= '0;
        end
      end
      ST_PUT: begin
        addr     <= au_sum;
        scrolled <= scroll_need;
      end
      ST_WRITE: begin
        wptr <= '0;
      end
      ST_SCROLL: begin
        if (pend) begin
          wptr <= wptr + 1'b1;
        end
      end
      ST_READ: begin
        in_range <= (32'(idx) < 32'(CELLS));
      end
      ST_RDATA: begin
        cell_data <= in_range ? ram_rdata : 16'h0000;
      end
      default: begin
      end
    endcase
  end

  // Result payload; read_cell is zero unless the command was a read
  always_comb begin
    res.cursor_row    = 5'(row);
    res.cursor_column = 7'(col);
    res.read_cell     = (op == OP_READ) ? cell_data : 16'h0000;
    res.did_scroll    = scrolled;
  end

endmodule

/* sv/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen engine: a COLUMNS x ROWS store of 16-bit cells
// (attribute high byte, character low byte) with a cursor, scrolling,
// clear and cell read-back.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents                               handshake
//  cmd      in   opcode, char_code, cell_index               valid/ready
//  rsp      out  cursor_row, cursor_column, read_cell,       valid/ready
//                did_scroll
//  cfg      in   index, data (foreground, background)        valid/ready
//
//  A put that scrolls copies the rows up through the single store port pair,
//  then blanks the bottom row; clear blanks every cell. After reset a clearing
//  pass runs with cmd.ready low; cfg writes are taken at any time. rsp is
//  registered, so a waiting result does not stop the next command from being
//  accepted.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  tcw_cmd_if.sink   cmd,
  tcw_rsp_if.source rsp,
  tcw_cfg_if.sink   cfg
);

  localparam int CELLS        = COLUMNS * ROWS;
  localparam int ADDR_W       = $clog2(CELLS);
  localparam int ROW_LAST_OUT = (ROWS - 1) % 32;

  logic [CFG_DATA_W-1:0] fg;
  logic [CFG_DATA_W-1:0] bg;
  logic [7:0]            attr;

  tcw_cmd_t          cmd_beat;
  logic              res_valid;
  logic              res_ready;
  tcw_result_t       res;
  logic              rsp_valid;
  tcw_result_t       rsp_data;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  // Colour registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FOREGROUND_RST;
      bg <= BACKGROUND_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FOREGROUND: fg <= cfg.data;
        CFG_BACKGROUND: bg <= cfg.data;
        default: begin
        end
      endcase
    end
  end
  assign attr = {bg, fg};

  assign cmd_beat = {cmd.opcode, cmd.char_code, cmd.cell_index};

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd       (cmd_beat),
    .attr      (attr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.cursor_row    = rsp_data.cursor_row;
  assign rsp.cursor_column = rsp_data.cursor_column;
  assign rsp.read_cell     = rsp_data.read_cell;
  assign rsp.did_scroll    = rsp_data.did_scroll;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("command accepted on two consecutive cycles");

  a_clear_pass: assert property (@(posedge clk)
    $fell(rst) |-> !cmd.ready)
    else $error("command taken before the clearing pass");

  a_column_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> 32'(rsp.cursor_column) < 32'(COLUMNS))
    else $error("cursor column beyond screen width");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.did_scroll |-> 32'(rsp.cursor_row) == 32'(ROW_LAST_OUT))
    else $error("scroll left the cursor off the last row");

endmodule
